### hdl/pfx_pkg.sv
// ----------------------------------------------------------------------------
// pfx_pkg
// types, constants and microcode for the postfix expression evaluator
// ----------------------------------------------------------------------------
package pfx_pkg;

  localparam int unsigned DATA_W    = 32;
  localparam int unsigned DIV_CNT_W = $clog2(DATA_W + 1);
  localparam int unsigned PC_W      = 5;

  // status codes
  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_INVALID   = 3'd1;
  localparam logic [2:0] ST_OVERFLOW  = 3'd2;
  localparam logic [2:0] ST_UNDERFLOW = 3'd3;
  localparam logic [2:0] ST_DIVZERO   = 3'd4;

  // character codes
  localparam logic [7:0] CH_ZERO  = 8'd48;
  localparam logic [7:0] CH_NINE  = 8'd57;
  localparam logic [7:0] CH_PLUS  = 8'd43;
  localparam logic [7:0] CH_MINUS = 8'd45;
  localparam logic [7:0] CH_MUL   = 8'd42;
  localparam logic [7:0] CH_DIV   = 8'd47;

  typedef enum logic [3:0] {
    ACT_NONE,
    ACT_FETCH,
    ACT_RD_TOP,
    ACT_RD_NEXT,
    ACT_LD_A,
    ACT_DIV_START,
    ACT_LD_DIV,
    ACT_LD_ALU,
    ACT_WB,
    ACT_PUSH,
    ACT_SET_ERR,
    ACT_EMIT
  } act_e;

  typedef enum logic [3:0] {
    CND_NEVER,
    CND_ALWAYS,
    CND_NO_VALID,
    CND_ERR,
    CND_DIGIT,
    CND_NOT_OP,
    CND_LT2,
    CND_NOT_DIV,
    CND_B_ZERO,
    CND_DIV_BUSY,
    CND_FULL,
    CND_NOT_LAST,
    CND_OUT_BUSY
  } cond_e;

  typedef struct packed {
    act_e             act;
    cond_e            cond;
    logic [PC_W-1:0]  target;
    logic [2:0]       err;
  } ctl_t;

  typedef struct packed {
    logic in_valid;
    logic err;
    logic digit;
    logic is_op;
    logic lt2;
    logic is_div;
    logic b_zero;
    logic div_busy;
    logic full;
    logic last;
    logic out_busy;
  } stat_t;

  // microcode addresses
  localparam logic [PC_W-1:0] U_FETCH   = 5'd0;
  localparam logic [PC_W-1:0] U_CHK_ERR = 5'd1;
  localparam logic [PC_W-1:0] U_CHK_DIG = 5'd2;
  localparam logic [PC_W-1:0] U_CHK_OP  = 5'd3;
  localparam logic [PC_W-1:0] U_RD_RHS  = 5'd4;
  localparam logic [PC_W-1:0] U_RD_LHS  = 5'd5;
  localparam logic [PC_W-1:0] U_LD_A    = 5'd6;
  localparam logic [PC_W-1:0] U_DIV_GO  = 5'd7;
  localparam logic [PC_W-1:0] U_DIV_WT  = 5'd8;
  localparam logic [PC_W-1:0] U_DIV_LD  = 5'd9;
  localparam logic [PC_W-1:0] U_ARITH   = 5'd10;
  localparam logic [PC_W-1:0] U_WB      = 5'd11;
  localparam logic [PC_W-1:0] U_PUSH_CK = 5'd12;
  localparam logic [PC_W-1:0] U_PUSH    = 5'd13;
  localparam logic [PC_W-1:0] U_BADSYM  = 5'd14;
  localparam logic [PC_W-1:0] U_UNDER   = 5'd15;
  localparam logic [PC_W-1:0] U_OVER    = 5'd16;
  localparam logic [PC_W-1:0] U_DIVZ    = 5'd17;
  localparam logic [PC_W-1:0] U_FIN     = 5'd18;
  localparam logic [PC_W-1:0] U_OUT_WT  = 5'd19;
  localparam logic [PC_W-1:0] U_EMIT    = 5'd20;

  function automatic ctl_t ucode(input logic [PC_W-1:0] pc);
    ctl_t w;
    w = '{act: ACT_NONE, cond: CND_ALWAYS, target: U_FETCH, err: ST_OK};
    unique case (pc)
      U_FETCH:   w = '{act: ACT_FETCH,     cond: CND_NO_VALID, target: U_FETCH,   err: ST_OK};
      U_CHK_ERR: w = '{act: ACT_NONE,      cond: CND_ERR,      target: U_FIN,     err: ST_OK};
      U_CHK_DIG: w = '{act: ACT_NONE,      cond: CND_DIGIT,    target: U_PUSH_CK, err: ST_OK};
      U_CHK_OP:  w = '{act: ACT_NONE,      cond: CND_NOT_OP,   target: U_BADSYM,  err: ST_OK};
      U_RD_RHS:  w = '{act: ACT_RD_TOP,    cond: CND_LT2,      target: U_UNDER,   err: ST_OK};
      U_RD_LHS:  w = '{act: ACT_RD_NEXT,   cond: CND_NEVER,    target: U_FETCH,   err: ST_OK};
      U_LD_A:    w = '{act: ACT_LD_A,      cond: CND_NOT_DIV,  target: U_ARITH,   err: ST_OK};
      U_DIV_GO:  w = '{act: ACT_DIV_START, cond: CND_B_ZERO,   target: U_DIVZ,    err: ST_OK};
      U_DIV_WT:  w = '{act: ACT_NONE,      cond: CND_DIV_BUSY, target: U_DIV_WT,  err: ST_OK};
      U_DIV_LD:  w = '{act: ACT_LD_DIV,    cond: CND_ALWAYS,   target: U_WB,      err: ST_OK};
      U_ARITH:   w = '{act: ACT_LD_ALU,    cond: CND_NEVER,    target: U_FETCH,   err: ST_OK};
      U_WB:      w = '{act: ACT_WB,        cond: CND_ALWAYS,   target: U_FIN,     err: ST_OK};
      U_PUSH_CK: w = '{act: ACT_NONE,      cond: CND_FULL,     target: U_OVER,    err: ST_OK};
      U_PUSH:    w = '{act: ACT_PUSH,      cond: CND_ALWAYS,   target: U_FIN,     err: ST_OK};
      U_BADSYM:  w = '{act: ACT_SET_ERR,   cond: CND_ALWAYS,   target: U_FIN,     err: ST_INVALID};
      U_UNDER:   w = '{act: ACT_SET_ERR,   cond: CND_ALWAYS,   target: U_FIN,     err: ST_UNDERFLOW};
      U_OVER:    w = '{act: ACT_SET_ERR,   cond: CND_ALWAYS,   target: U_FIN,     err: ST_OVERFLOW};
      U_DIVZ:    w = '{act: ACT_SET_ERR,   cond: CND_ALWAYS,   target: U_FIN,     err: ST_DIVZERO};
      U_FIN:     w = '{act: ACT_RD_TOP,    cond: CND_NOT_LAST, target: U_FETCH,   err: ST_OK};
      U_OUT_WT:  w = '{act: ACT_NONE,      cond: CND_OUT_BUSY, target: U_OUT_WT,  err: ST_OK};
      U_EMIT:    w = '{act: ACT_EMIT,      cond: CND_ALWAYS,   target: U_FETCH,   err: ST_OK};
      default:   w = '{act: ACT_NONE,      cond: CND_ALWAYS,   target: U_FETCH,   err: ST_OK};
    endcase
    return w;
  endfunction

endpackage

### hdl/pfx_if.sv
// ----------------------------------------------------------------------------
// pfx_if
// valid/ready channels of the postfix expression evaluator
// ----------------------------------------------------------------------------
interface pfx_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] symbol;
  logic       last;

  modport source (output valid, output symbol, output last, input ready);
  modport sink (input valid, input symbol, input last, output ready);
endinterface

interface pfx_out_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] value;
  logic [2:0]         status;

  modport source (output valid, output value, output status, input ready);
  modport sink (input valid, input value, input status, output ready);
endinterface

### hdl/pfx_div.sv
// ----------------------------------------------------------------------------
// pfx_div
// serial signed divider, one quotient bit per cycle, truncates toward zero
// ----------------------------------------------------------------------------
module pfx_div import pfx_pkg::*; (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start_i,
  input  logic [DATA_W-1:0] dividend_i,
  input  logic [DATA_W-1:0] divisor_i,
  output logic              busy_o,
  output logic [DATA_W-1:0] quot_o
);

  logic [DIV_CNT_W-1:0] cnt_q, cnt_d;
  logic [DATA_W-1:0]    q_q, q_d, r_q, r_d, d_q, d_d;
  logic                 neg_q, neg_d;
  logic [DATA_W:0]      r_shift, diff;

  assign r_shift = {r_q, q_q[DATA_W-1]};
  assign diff    = r_shift - {1'b0, d_q};

  always_comb begin
    cnt_d = cnt_q;
    q_d   = q_q;
    r_d   = r_q;
    d_d   = d_q;
    neg_d = neg_q;
    if (start_i) begin
      neg_d = dividend_i[DATA_W-1] ^ divisor_i[DATA_W-1];
      q_d   = dividend_i[DATA_W-1] ? (~dividend_i + 1'b1) : dividend_i;
      d_d   = divisor_i[DATA_W-1] ? (~divisor_i + 1'b1) : divisor_i;
      r_d   = '0;
      cnt_d = DIV_CNT_W'(DATA_W);
    end else if (cnt_q != '0) begin
      q_d   = {q_q[DATA_W-2:0], ~diff[DATA_W]};
      r_d   = diff[DATA_W] ? r_shift[DATA_W-1:0] : diff[DATA_W-1:0];
      cnt_d = cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q <= '0;
    end else begin
      cnt_q <= cnt_d;
    end
  end

  always_ff @(posedge clk_i) begin
    q_q   <= q_d;
    r_q   <= r_d;
    d_q   <= d_d;
    neg_q <= neg_d;
  end

  assign busy_o = (cnt_q != '0);
  assign quot_o = neg_q ? (~q_q + 1'b1) : q_q;

endmodule

### hdl/pfx_seq.sv
// ----------------------------------------------------------------------------
// pfx_seq
// microcode sequencer: step counter, control store and conditional jumps
// ----------------------------------------------------------------------------
module pfx_seq import pfx_pkg::*; (
  input  logic  clk_i,
  input  logic  rst_ni,
  input  stat_t stat_i,
  output ctl_t  ctl_o
);

  logic [PC_W-1:0] pc_q, pc_d;
  ctl_t            ctl;
  logic            take;

  assign ctl = ucode(pc_q);

  always_comb begin
    case (ctl.cond)
      CND_NEVER:    take = 1'b0;
      CND_ALWAYS:   take = 1'b1;
      CND_NO_VALID: take = !stat_i.in_valid;
      CND_ERR:      take = stat_i.err;
      CND_DIGIT:    take = stat_i.digit;
      CND_NOT_OP:   take = !stat_i.is_op;
      CND_LT2:      take = stat_i.lt2;
      CND_NOT_DIV:  take = !stat_i.is_div;
      CND_B_ZERO:   take = stat_i.b_zero;
      CND_DIV_BUSY: take = stat_i.div_busy;
      CND_FULL:     take = stat_i.full;
      CND_NOT_LAST: take = !stat_i.last;
      CND_OUT_BUSY: take = stat_i.out_busy;
      default:      take = 1'b0;
    endcase
    pc_d = take ? ctl.target : pc_q + 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pc_q <= U_FETCH;
    end else begin
      pc_q <= pc_d;
    end
  end

  assign ctl_o = ctl;

endmodule

### hdl/pfx_dp.sv
// ----------------------------------------------------------------------------
// pfx_dp
// datapath: operand stack memory, operand registers, alu, divider, output reg
// ----------------------------------------------------------------------------
module pfx_dp import pfx_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic                     clk_i,
  input  logic                     rst_ni,
  input  ctl_t                     ctl_i,
  output stat_t                    stat_o,
  input  logic                     in_valid_i,
  output logic                     in_ready_o,
  input  logic [7:0]               in_symbol_i,
  input  logic                     in_last_i,
  output logic                     out_valid_o,
  input  logic                     out_ready_i,
  output logic signed [DATA_W-1:0] out_value_o,
  output logic [2:0]               out_status_o
);

  localparam int unsigned AW = $clog2(STACK_DEPTH);
  localparam int unsigned CW = $clog2(STACK_DEPTH + 1);

  logic [DATA_W-1:0] mem [STACK_DEPTH];
  logic [DATA_W-1:0] rd_q, a_q, b_q, res_q, alu_res, div_quot;
  logic [7:0]        sym_q;
  logic              last_q;
  logic [CW-1:0]     cnt_q, cnt_d;
  logic [2:0]        err_q, err_d;
  logic              out_valid_q, out_valid_d;
  logic [DATA_W-1:0] out_value_q;
  logic [2:0]        out_status_q;
  logic [CW-1:0]     cnt_m1, cnt_m2;
  logic              fetch, digit, is_op, div_busy;
  logic              rd_en, wr_en;
  logic [AW-1:0]     rd_addr, wr_addr;
  logic [DATA_W-1:0] wr_data;

  assign cnt_m1 = cnt_q - 1'b1;
  assign cnt_m2 = cnt_q - CW'(2);
  assign fetch  = (ctl_i.act == ACT_FETCH);
  assign digit  = (sym_q >= CH_ZERO) && (sym_q <= CH_NINE);
  assign is_op  = (sym_q == CH_PLUS) || (sym_q == CH_MINUS) ||
                  (sym_q == CH_MUL) || (sym_q == CH_DIV);

  // stack port control
  always_comb begin
    rd_en   = 1'b0;
    rd_addr = cnt_m1[AW-1:0];
    wr_en   = 1'b0;
    wr_addr = cnt_q[AW-1:0];
    wr_data = {{(DATA_W-4){1'b0}}, 4'(sym_q - CH_ZERO)};
    case (ctl_i.act)
      ACT_RD_TOP: rd_en = 1'b1;
      ACT_RD_NEXT: begin
        rd_en   = 1'b1;
        rd_addr = cnt_m2[AW-1:0];
      end
      ACT_PUSH: wr_en = 1'b1;
      ACT_WB: begin
        wr_en   = 1'b1;
        wr_addr = cnt_m2[AW-1:0];
        wr_data = res_q;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_q <= mem[rd_addr];
    end
  end

  always_comb begin
    case (sym_q)
      CH_PLUS:  alu_res = a_q + b_q;
      CH_MINUS: alu_res = a_q - b_q;
      default:  alu_res = a_q * b_q;
    endcase
  end

  pfx_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    ((ctl_i.act == ACT_DIV_START) && (b_q != '0)),
    .dividend_i (a_q),
    .divisor_i  (b_q),
    .busy_o     (div_busy),
    .quot_o     (div_quot)
  );

  always_ff @(posedge clk_i) begin
    if (fetch && in_valid_i) begin
      sym_q  <= in_symbol_i;
      last_q <= in_last_i;
    end
    if (ctl_i.act == ACT_RD_NEXT) begin
      b_q <= rd_q;
    end
    if (ctl_i.act == ACT_LD_A) begin
      a_q <= rd_q;
    end
    if (ctl_i.act == ACT_LD_ALU) begin
      res_q <= alu_res;
    end else if (ctl_i.act == ACT_LD_DIV) begin
      res_q <= div_quot;
    end
    if (ctl_i.act == ACT_EMIT) begin
      if (err_q != ST_OK) begin
        out_value_q  <= '0;
        out_status_q <= err_q;
      end else if (cnt_q == '0) begin
        out_value_q  <= '0;
        out_status_q <= ST_UNDERFLOW;
      end else begin
        out_value_q  <= rd_q;
        out_status_q <= ST_OK;
      end
    end
  end

  always_comb begin
    cnt_d       = cnt_q;
    err_d       = err_q;
    out_valid_d = out_valid_q && !out_ready_i;
    case (ctl_i.act)
      ACT_PUSH:    cnt_d = cnt_q + 1'b1;
      ACT_WB:      cnt_d = cnt_m1;
      ACT_SET_ERR: err_d = ctl_i.err;
      ACT_EMIT: begin
        cnt_d       = '0;
        err_d       = ST_OK;
        out_valid_d = 1'b1;
      end
      default: ;
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q       <= '0;
      err_q       <= ST_OK;
      out_valid_q <= 1'b0;
    end else begin
      cnt_q       <= cnt_d;
      err_q       <= err_d;
      out_valid_q <= out_valid_d;
    end
  end

  assign stat_o = '{
    in_valid: in_valid_i,
    err:      (err_q != ST_OK),
    digit:    digit,
    is_op:    is_op,
    lt2:      (cnt_q < CW'(2)),
    is_div:   (sym_q == CH_DIV),
    b_zero:   (b_q == '0),
    div_busy: div_busy,
    full:     (cnt_q == CW'(STACK_DEPTH)),
    last:     last_q,
    out_busy: out_valid_q
  };

  assign in_ready_o   = fetch;
  assign out_valid_o  = out_valid_q;
  assign out_value_o  = out_value_q;
  assign out_status_o = out_status_q;

endmodule

### hdl/postfix_expression_evaluator.sv
// ----------------------------------------------------------------------------
// postfix_expression_evaluator
// evaluates postfix expressions one character per transfer on a 32-bit stack
// ----------------------------------------------------------------------------
//  channel | dir | payload                     | transfer
//  in_i    | in  | symbol[7:0], last           | valid && ready
//  out_o   | out | value[31:0] signed, status  | valid && ready, one per last
//
//  a microcoded sequencer runs each character through a short step program
//  digit: push step; + - *: alu step; /: start, wait on and load the serial divider
//  a last character adds the output wait and emit steps, the result shows the cycle after the emit step
//  input is taken only in the fetch step; a held result stalls only the next emit
//  reset clears the step counter, stack count, error code and output valid
// ----------------------------------------------------------------------------
module postfix_expression_evaluator import pfx_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic      clk_i,
  input  logic      rst_ni,
  pfx_in_if.sink    in_i,
  pfx_out_if.source out_o
);

  ctl_t  ctl;
  stat_t stat;

  pfx_seq u_seq (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .stat_i (stat),
    .ctl_o  (ctl)
  );

  pfx_dp #(
    .STACK_DEPTH (STACK_DEPTH)
  ) u_dp (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctl_i        (ctl),
    .stat_o       (stat),
    .in_valid_i   (in_i.valid),
    .in_ready_o   (in_i.ready),
    .in_symbol_i  (in_i.symbol),
    .in_last_i    (in_i.last),
    .out_valid_o  (out_o.valid),
    .out_ready_i  (out_o.ready),
    .out_value_o  (out_o.value),
    .out_status_o (out_o.status)
  );

endmodule

### hdl/pfx_checker.sv
// ----------------------------------------------------------------------------
// pfx_checker
// port-level checks of the postfix expression evaluator
// ----------------------------------------------------------------------------
module pfx_checker import pfx_pkg::*; (
  input logic        clk_i,
  input logic        rst_ni,
  input logic        out_valid_i,
  input logic        out_ready_i,
  input logic [31:0] out_value_i,
  input logic [2:0]  out_status_i
);

  a_out_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> out_valid_i)
    else $error("result dropped before transfer");

  a_out_stable: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && !out_ready_i |=> $stable(out_value_i) && $stable(out_status_i))
    else $error("result changed while stalled");

  a_status_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i |-> out_status_i <= ST_DIVZERO)
    else $error("status code out of range");

  a_err_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_i && (out_status_i != ST_OK) |-> out_value_i == '0)
    else $error("nonzero value with error status");

endmodule

bind postfix_expression_evaluator pfx_checker u_pfx_checker (
  .clk_i        (clk_i),
  .rst_ni       (rst_ni),
  .out_valid_i  (out_o.valid),
  .out_ready_i  (out_o.ready),
  .out_value_i  (out_o.value),
  .out_status_i (out_o.status)
);

### verif/pfx_result_checker.sv
// ----------------------------------------------------------------------------
// pfx_result_checker
// watches both channels of the postfix expression evaluator, keeps its own
// operand stack and error code, predicts one result per last character and
// compares every output transfer with the oldest prediction
// ----------------------------------------------------------------------------
module pfx_result_checker import pfx_pkg::*; #(
  parameter int unsigned STACK_DEPTH = 16
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               in_valid_i,
  input  logic               in_ready_i,
  input  logic [7:0]         in_symbol_i,
  input  logic               in_last_i,
  input  logic               out_valid_i,
  input  logic               out_ready_i,
  input  logic signed [31:0] out_value_i,
  input  logic [2:0]         out_status_i,
  output int unsigned        mismatch_cnt_o,
  output int unsigned        pending_cnt_o,
  output int unsigned        result_cnt_o,
  output int unsigned        error_result_cnt_o
);
  timeunit 1ns;
  timeprecision 1ps;

  localparam int unsigned MAX_REPORTS = 10;

  typedef struct packed {
    logic [31:0] value;
    logic [2:0]  status;
  } expr_result_t;

  logic [31:0]  operand_q [STACK_DEPTH];
  int unsigned  depth;
  logic [2:0]   first_err;
  expr_result_t awaited_results [$];
  int unsigned  mismatches;
  int unsigned  results_seen;
  int unsigned  error_results;

  function automatic logic [31:0] trunc_quotient(input logic [31:0] dividend,
                                                 input logic [31:0] divisor);
    logic [31:0] mag_n;
    logic [31:0] mag_d;
    logic [31:0] quot;
    mag_n = dividend[31] ? -dividend : dividend;
    mag_d = divisor[31] ? -divisor : divisor;
    quot  = mag_n / mag_d;
    return (dividend[31] ^ divisor[31]) ? -quot : quot;
  endfunction

  task automatic note_mismatch(input string what);
    mismatches++;
    if (mismatches <= MAX_REPORTS) begin
      $display("%0t mismatch: %s", $time, what);
    end
  endtask

  task automatic evaluate_symbol(input logic [7:0] sym, input logic last);
    logic [31:0]  lhs;
    logic [31:0]  rhs;
    logic [31:0]  res;
    expr_result_t outcome;
    if (first_err == ST_OK) begin
      if (sym >= CH_ZERO && sym <= CH_NINE) begin
        if (depth >= STACK_DEPTH) begin
          first_err = ST_OVERFLOW;
        end else begin
          operand_q[depth] = 32'(sym - CH_ZERO);
          depth++;
        end
      end else if (sym == CH_PLUS || sym == CH_MINUS || sym == CH_MUL || sym == CH_DIV) begin
        if (depth < 2) begin
          first_err = ST_UNDERFLOW;
        end else begin
          rhs = operand_q[depth-1];
          lhs = operand_q[depth-2];
          if (sym == CH_DIV && rhs == '0) begin
            first_err = ST_DIVZERO;
          end else begin
            case (sym)
              CH_PLUS:  res = lhs + rhs;
              CH_MINUS: res = lhs - rhs;
              CH_MUL:   res = lhs * rhs;
              default:  res = trunc_quotient(lhs, rhs);
            endcase
            depth--;
            operand_q[depth-1] = res;
          end
        end
      end else begin
        first_err = ST_INVALID;
      end
    end
    if (last) begin
      outcome.value  = '0;
      outcome.status = first_err;
      if (first_err == ST_OK) begin
        if (depth == 0) begin
          outcome.status = ST_UNDERFLOW;
        end else begin
          outcome.value = operand_q[depth-1];
        end
      end
      awaited_results.push_back(outcome);
      depth     = 0;
      first_err = ST_OK;
    end
  endtask

  task automatic check_result();
    expr_result_t want;
    if (awaited_results.size() == 0) begin
      note_mismatch($sformatf("result with nothing expected: value %0d status %0d",
                              out_value_i, out_status_i));
    end else begin
      want = awaited_results.pop_front();
      results_seen++;
      if (want.status != ST_OK) begin
        error_results++;
      end
      if (out_value_i !== want.value || out_status_i !== want.status) begin
        note_mismatch($sformatf("expected value %0d status %0d, got value %0d status %0d",
                                $signed(want.value), want.status, out_value_i,
                                out_status_i));
      end
    end
  endtask

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      depth         = 0;
      first_err     = ST_OK;
      mismatches    = 0;
      results_seen  = 0;
      error_results = 0;
      awaited_results.delete();
    end else begin
      // older result leaves first, a new last character can only add behind it
      if (out_valid_i && out_ready_i) begin
        check_result();
      end
      if (in_valid_i && in_ready_i) begin
        evaluate_symbol(in_symbol_i, in_last_i);
      end
    end
    mismatch_cnt_o     <= mismatches;
    pending_cnt_o      <= awaited_results.size();
    result_cnt_o       <= results_seen;
    error_result_cnt_o <= error_results;
  end

endmodule

### verif/tb.sv
// ----------------------------------------------------------------------------
// tb
// stimulus and verdict for the postfix expression evaluator: directed
// expressions for the field extremes, every operator and each error but
// overflow, then random well-formed, overflowing, wrapping and malformed
// expressions under three idle patterns and one long output hold-off
// ----------------------------------------------------------------------------
module tb;
  timeunit 1ns;
  timeprecision 1ps;

  import pfx_pkg::*;

  localparam int unsigned CLK_PERIOD   = 12;
  localparam int unsigned RESET_CYCLES = 6;
  localparam int unsigned STACK_DEPTH  = 16;
  localparam int unsigned RANDOM_CHARS = 1850;
  localparam int unsigned HOLD_CYCLES  = 300;
  localparam int unsigned DRAIN_CYCLES = 100;
  localparam int unsigned LIMIT_CYCLES = 1000000;

  localparam logic [7:0] OPERATORS [4] = '{CH_PLUS, CH_MINUS, CH_MUL, CH_DIV};
  localparam string      NOISE_SET     = "0123456789+-*/";

  typedef struct packed {
    logic [7:0] symbol;
    logic       last;
  } expr_char_t;

  logic        clk_i = 1'b0;
  logic        rst_ni;
  int unsigned src_idle_pct;
  int unsigned snk_idle_pct;
  bit          hold_req;
  int unsigned chars_sent;
  int unsigned exprs_sent;
  expr_char_t  char_q [$];

  int unsigned mismatch_cnt;
  int unsigned pending_cnt;
  int unsigned result_cnt;
  int unsigned error_result_cnt;

  pfx_in_if  in_ch ();
  pfx_out_if out_ch ();

  postfix_expression_evaluator #(
    .STACK_DEPTH (STACK_DEPTH)
  ) dut (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .in_i   (in_ch),
    .out_o  (out_ch)
  );

  pfx_result_checker #(
    .STACK_DEPTH (STACK_DEPTH)
  ) result_checker (
    .clk_i              (clk_i),
    .rst_ni             (rst_ni),
    .in_valid_i         (in_ch.valid),
    .in_ready_i         (in_ch.ready),
    .in_symbol_i        (in_ch.symbol),
    .in_last_i          (in_ch.last),
    .out_valid_i        (out_ch.valid),
    .out_ready_i        (out_ch.ready),
    .out_value_i        (out_ch.value),
    .out_status_i       (out_ch.status),
    .mismatch_cnt_o     (mismatch_cnt),
    .pending_cnt_o      (pending_cnt),
    .result_cnt_o       (result_cnt),
    .error_result_cnt_o (error_result_cnt)
  );

  always #(CLK_PERIOD / 2) clk_i = ~clk_i;

  task automatic add_symbol(input logic [7:0] sym, input logic last);
    char_q.push_back('{symbol: sym, last: last});
  endtask

  task automatic add_text(input string text, input bit ends_expr);
    for (int i = 0; i < text.len(); i++) begin
      add_symbol(text[i], ends_expr && (i == text.len() - 1));
    end
  endtask

  task automatic add_digit();
    add_symbol(CH_ZERO + 8'($urandom_range(9)), 1'b0);
  endtask

  task automatic build_expression();
    int unsigned kind;
    int unsigned operands;
    int unsigned pushed;
    int unsigned depth;
    kind = $urandom_range(99);
    if (kind < 65) begin
      operands = ($urandom_range(9) == 0) ? $urandom_range(STACK_DEPTH - 6, STACK_DEPTH)
                                          : $urandom_range(1, 6);
      pushed = 0;
      depth  = 0;
      forever begin
        // now and then stop early and leave operands behind
        if (pushed == operands && (depth < 2 || $urandom_range(6) == 0)) break;
        if (pushed < operands && (depth < 2 || $urandom_range(1) == 0)) begin
          add_digit();
          pushed++;
          depth++;
        end else begin
          add_symbol(OPERATORS[$urandom_range(3)], 1'b0);
          depth--;
        end
      end
    end else if (kind < 72) begin
      repeat (STACK_DEPTH + $urandom_range(1, 2)) add_digit();
      if ($urandom_range(1) == 1) begin
        add_symbol(OPERATORS[$urandom_range(3)], 1'b0);
      end
    end else if (kind < 80) begin
      // 2 * 8^10 wraps to the most negative value
      add_text("2", 1'b0);
      repeat (10) add_text("8*", 1'b0);
      case ($urandom_range(3))
        0:       add_text("01-/", 1'b0);
        1:       add_text("1-", 1'b0);
        2:       add_text("2*", 1'b0);
        default: add_text("01-*", 1'b0);
      endcase
    end else begin
      repeat ($urandom_range(1, 6)) begin
        if ($urandom_range(1) == 1) begin
          add_symbol(8'($urandom_range(255)), 1'b0);
        end else begin
          add_symbol(NOISE_SET[$urandom_range(NOISE_SET.len() - 1)], 1'b0);
        end
      end
    end
    char_q[char_q.size() - 1].last = 1'b1;
  endtask

  task automatic send_queued();
    expr_char_t c;
    while (char_q.size() != 0) begin
      c = char_q.pop_front();
      while ($urandom_range(99) < src_idle_pct) begin
        in_ch.valid <= 1'b0;
        @(posedge clk_i);
      end
      in_ch.valid  <= 1'b1;
      in_ch.symbol <= c.symbol;
      in_ch.last   <= c.last;
      do @(posedge clk_i); while (!in_ch.ready);
      chars_sent++;
      if (c.last) begin
        exprs_sent++;
      end
    end
  endtask

  // output side, with one long hold-off on request
  initial begin
    bit hold_done;
    hold_done = 1'b0;
    out_ch.ready <= 1'b0;
    forever begin
      @(posedge clk_i);
      if (hold_req && !hold_done) begin
        hold_done = 1'b1;
        out_ch.ready <= 1'b0;
        repeat (HOLD_CYCLES) @(posedge clk_i);
      end
      out_ch.ready <= ($urandom_range(99) >= snk_idle_pct);
    end
  end

  initial begin
    repeat (LIMIT_CYCLES) @(posedge clk_i);
    $display("timeout after %0d cycles", LIMIT_CYCLES);
    $display("postfix_expression_evaluator test failed");
    $finish;
  end

  initial begin
    int unsigned phase_chars;
    rst_ni       <= 1'b0;
    in_ch.valid  <= 1'b0;
    in_ch.symbol <= '0;
    in_ch.last   <= 1'b0;
    src_idle_pct = 7;
    snk_idle_pct = 48;
    hold_req     = 1'b0;
    chars_sent   = 0;
    exprs_sent   = 0;
    repeat (RESET_CYCLES) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    add_text("9", 1'b1);
    add_text("0", 1'b1);
    add_text("93-7*4/2+", 1'b1);
    add_text("27-3/", 1'b1);
    add_symbol(8'hff, 1'b1);
    add_symbol(8'h00, 1'b0);
    add_text("5", 1'b1);
    add_text("+", 1'b1);
    add_text("50/", 1'b1);
    add_text("12", 1'b1);
    send_queued();

    for (int phase = 0; phase < 3; phase++) begin
      case (phase)
        0:       begin src_idle_pct = 7;  snk_idle_pct = 48; end
        1:       begin src_idle_pct = 48; snk_idle_pct = 7;  end
        default: begin src_idle_pct = 0;  snk_idle_pct = 0;  hold_req = 1'b1; end
      endcase
      phase_chars = 0;
      while (phase_chars < RANDOM_CHARS / 3) begin
        build_expression();
        phase_chars += char_q.size();
        send_queued();
      end
    end
    in_ch.valid <= 1'b0;

    while (pending_cnt != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);

    $display("covered %0d characters in %0d expressions, %0d results compared, %0d of them errors",
             chars_sent, exprs_sent, result_cnt, error_result_cnt);
    $display("idle mixes 7/48, 48/7 and 0/0 percent, one %0d-cycle output hold-off",
             HOLD_CYCLES);
    if (mismatch_cnt == 0 && pending_cnt == 0) begin
      $display("postfix_expression_evaluator test passed");
    end else begin
      $display("%0d mismatches, %0d results never seen", mismatch_cnt, pending_cnt);
      $display("postfix_expression_evaluator test failed");
    end
    $finish;
  end

endmodule
